FILE: hdl/savitzky_golay_vector_filter_defines.svh
// ----------------------------------------------------------------------------
// Savitzky-Golay vector filter assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SAVITZKY_GOLAY_VECTOR_FILTER_DEFINES_SVH
`define SAVITZKY_GOLAY_VECTOR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SGVF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SGVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SGVF_ASSERT(lbl, ante, cons, msg)
`define SGVF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/sgvf_pkg.sv
// ----------------------------------------------------------------------------
// Savitzky-Golay vector filter package
// Sizes, register and command codes, sequencer states and arithmetic helpers.
// ----------------------------------------------------------------------------
package sgvf_pkg;

  localparam int MAX_HALF_WIDTH = 15;
  localparam int HISTORY_DEPTH  = 64;
  localparam int TAP_SLOTS      = 2 * MAX_HALF_WIDTH + 1;
  localparam int TAP_AW         = $clog2(TAP_SLOTS);
  localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
  localparam int FILL_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SPAN_W         = 6;
  localparam int CMP_W          = (FILL_W > SPAN_W) ? FILL_W : SPAN_W;
  localparam int DATA_W         = 32;
  localparam int PROD_W         = 64;
  localparam int CFG_AW         = 2;
  localparam int AX_W           = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_HALF_WIDTH    = 2'd0,
    REG_OUTPUT_DELAY  = 2'd1,
    REG_INVERSE_SCALE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD_WEIGHT = 1'b0,
    CMD_PUSH_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [AX_W-1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_SMUL,
    ST_SACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic scale_op;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  // add half an lsb of q16 and floor-shift by 16
  function automatic logic signed [PROD_W-1:0] round16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.val  = v[DATA_W-1:0];
    r.clip = 1'b0;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.val  = 32'sh7fff_ffff;
      r.clip = 1'b1;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/sgvf_if.sv
// ----------------------------------------------------------------------------
// Savitzky-Golay vector filter channel interfaces
// Valid/ready channels for configuration, command input and filtered output.
// ----------------------------------------------------------------------------
interface sgvf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [sgvf_pkg::CFG_AW-1:0]           reg_index;
  logic [sgvf_pkg::DATA_W-1:0]           wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface sgvf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [4:0]                            weight_index;
  logic signed [sgvf_pkg::DATA_W-1:0]    weight_value;
  logic signed [sgvf_pkg::DATA_W-1:0]    sample_x;
  logic signed [sgvf_pkg::DATA_W-1:0]    sample_y;
  logic signed [sgvf_pkg::DATA_W-1:0]    sample_z;

  modport source (output valid, output command, output weight_index, output weight_value,
                  output sample_x, output sample_y, output sample_z, input ready);
  modport sink   (input valid, input command, input weight_index, input weight_value,
                  input sample_x, input sample_y, input sample_z, output ready);
endinterface

interface sgvf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sgvf_pkg::DATA_W-1:0]    out_x;
  logic signed [sgvf_pkg::DATA_W-1:0]    out_y;
  logic signed [sgvf_pkg::DATA_W-1:0]    out_z;
  logic                                  window_ready;
  logic                                  clipped;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output window_ready, output clipped, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input window_ready, input clipped, output ready);
endinterface

FILE: hdl/savitzky_golay_vector_filter.sv
// ----------------------------------------------------------------------------
// Savitzky-Golay vector filter
// Three-axis fixed-point window filter on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// cfg_i    in   reg_index, wdata (half width, output delay, inverse scale)
// in_i     in   command, weight_index, weight_value, sample_x/y/z
// out_o    out  out_x/y/z, window_ready, clipped (one beat per sample push)
//
// weight load: written straight to the tap table from idle. sample push
// with a full window, taps = 2*m+1: per tap one history/weight read and
// three multiply-accumulate pairs on the single multiplier, then three
// round/scale passes on it; without a full window the push skips them.
// no clearing pass after reset: the fill count keeps unwritten history unread.
// a new beat is taken while a result waits on out_o; a finished push stalls
// only until the output register is free.
// ----------------------------------------------------------------------------
`include "savitzky_golay_vector_filter_defines.svh"

module savitzky_golay_vector_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  sgvf_cfg_if.sink          cfg_i,
  sgvf_in_if.sink           in_i,
  sgvf_out_if.source        out_o
);

  sgvf_pkg::state_e state_q, state_d;
  sgvf_pkg::ctl_t   ctl;

  logic [3:0]                          half_width_q;
  logic [4:0]                          output_delay_q;
  logic signed [sgvf_pkg::DATA_W-1:0]  inverse_scale_q;

  logic [sgvf_pkg::HIST_AW-1:0]        wp_q;
  logic [sgvf_pkg::FILL_W-1:0]         fill_q;
  logic [sgvf_pkg::HIST_AW-1:0]        rd_ptr_q;
  logic [sgvf_pkg::TAP_AW-1:0]         tap_q;
  logic [4:0]                          taps_q;
  logic [sgvf_pkg::AX_W-1:0]           ax_q;

  logic [2:0][sgvf_pkg::DATA_W-1:0]    hist_mem [sgvf_pkg::HISTORY_DEPTH];
  logic [sgvf_pkg::DATA_W-1:0]         tap_mem  [sgvf_pkg::TAP_SLOTS];
  logic [2:0][sgvf_pkg::DATA_W-1:0]    hist_rd_q;
  logic signed [sgvf_pkg::DATA_W-1:0]  w_rd_q;

  logic signed [sgvf_pkg::PROD_W-1:0]  acc_q [3];
  logic signed [sgvf_pkg::PROD_W-1:0]  prod_q;
  logic signed [sgvf_pkg::DATA_W-1:0]  s_q;
  logic signed [sgvf_pkg::DATA_W-1:0]  res_q [3];
  logic                                win_q;
  logic                                clip_q;

  logic                                out_valid_q;
  logic signed [sgvf_pkg::DATA_W-1:0]  out_x_q, out_y_q, out_z_q;
  logic                                out_win_q, out_clip_q;

  logic                                in_acc;
  logic                                cfg_acc;
  logic [3:0]                          m_clamp;
  logic [4:0]                          taps_c;
  logic [sgvf_pkg::SPAN_W-1:0]         span_c;
  logic                                win_ok;
  logic [sgvf_pkg::CMP_W:0]            start_ptr_w;
  logic                                tap_last;
  logic signed [sgvf_pkg::DATA_W-1:0]  hist_axis;
  logic signed [sgvf_pkg::DATA_W-1:0]  mul_a, mul_b;
  logic signed [sgvf_pkg::PROD_W-1:0]  mul_p;
  sgvf_pkg::sat_t                      sat_rnd, sat_scl;

  assign in_acc  = in_i.valid & ctl.in_ready;
  assign cfg_acc = cfg_i.valid & cfg_i.ready;

  // window geometry
  always_comb begin
    if (half_width_q > 4'(sgvf_pkg::MAX_HALF_WIDTH)) begin
      m_clamp = 4'(sgvf_pkg::MAX_HALF_WIDTH);
    end else begin
      m_clamp = half_width_q;
    end
    taps_c = {m_clamp, 1'b1};
    span_c = sgvf_pkg::SPAN_W'(taps_c) + sgvf_pkg::SPAN_W'(output_delay_q);
    win_ok = sgvf_pkg::CMP_W'(fill_q) >= sgvf_pkg::CMP_W'(span_c);
    if (sgvf_pkg::CMP_W'(wp_q) >= sgvf_pkg::CMP_W'(span_c)) begin
      start_ptr_w = (sgvf_pkg::CMP_W+1)'(wp_q) - (sgvf_pkg::CMP_W+1)'(span_c);
    end else begin
      start_ptr_w = (sgvf_pkg::CMP_W+1)'(wp_q) + (sgvf_pkg::CMP_W+1)'(sgvf_pkg::HISTORY_DEPTH)
                    - (sgvf_pkg::CMP_W+1)'(span_c);
    end
  end

  assign tap_last = (5'(tap_q) == taps_q - 5'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgvf_pkg::ST_IDLE: begin
        if (in_acc && in_i.command == sgvf_pkg::CMD_PUSH_SAMPLE) begin
          state_d = sgvf_pkg::ST_START;
        end
      end
      sgvf_pkg::ST_START: state_d = win_ok ? sgvf_pkg::ST_RD : sgvf_pkg::ST_DONE;
      sgvf_pkg::ST_RD:    state_d = sgvf_pkg::ST_MUL;
      sgvf_pkg::ST_MUL:   state_d = sgvf_pkg::ST_ACC;
      sgvf_pkg::ST_ACC: begin
        if (ax_q != sgvf_pkg::AX_Z) begin
          state_d = sgvf_pkg::ST_MUL;
        end else if (tap_last) begin
          state_d = sgvf_pkg::ST_RND;
        end else begin
          state_d = sgvf_pkg::ST_RD;
        end
      end
      sgvf_pkg::ST_RND:   state_d = sgvf_pkg::ST_SMUL;
      sgvf_pkg::ST_SMUL:  state_d = sgvf_pkg::ST_SACC;
      sgvf_pkg::ST_SACC: begin
        state_d = (ax_q == sgvf_pkg::AX_Z) ? sgvf_pkg::ST_DONE : sgvf_pkg::ST_RND;
      end
      sgvf_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = sgvf_pkg::ST_IDLE;
        end
      end
      default: state_d = sgvf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    case (state_q)
      sgvf_pkg::ST_IDLE: ctl.in_ready = 1'b1;
      sgvf_pkg::ST_SMUL: ctl.scale_op = 1'b1;
      sgvf_pkg::ST_DONE: ctl.out_load = !out_valid_q || out_o.ready;
      default: ctl = '0;
    endcase
  end

  // shared multiplier
  always_comb begin
    case (ax_q)
      sgvf_pkg::AX_X: hist_axis = hist_rd_q[2];
      sgvf_pkg::AX_Y: hist_axis = hist_rd_q[1];
      default:        hist_axis = hist_rd_q[0];
    endcase
    mul_a = ctl.scale_op ? s_q : hist_axis;
    mul_b = ctl.scale_op ? inverse_scale_q : w_rd_q;
    mul_p = sgvf_pkg::PROD_W'(mul_a) * sgvf_pkg::PROD_W'(mul_b);
  end

  assign sat_rnd = sgvf_pkg::sat32(sgvf_pkg::round16(acc_q[ax_q]));
  assign sat_scl = sgvf_pkg::sat32(sgvf_pkg::round16(prod_q));

  // memories
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.command == sgvf_pkg::CMD_PUSH_SAMPLE) begin
      hist_mem[wp_q] <= {in_i.sample_x, in_i.sample_y, in_i.sample_z};
    end
    hist_rd_q <= hist_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.command == sgvf_pkg::CMD_LOAD_WEIGHT &&
        32'(in_i.weight_index) < sgvf_pkg::TAP_SLOTS) begin
      tap_mem[sgvf_pkg::TAP_AW'(in_i.weight_index)] <= in_i.weight_value;
    end
    w_rd_q <= tap_mem[tap_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= sgvf_pkg::ST_IDLE;
      half_width_q    <= 4'd2;
      output_delay_q  <= 5'd0;
      inverse_scale_q <= 32'sd65536;
      wp_q            <= '0;
      fill_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_i.reg_index)
          sgvf_pkg::REG_HALF_WIDTH:    half_width_q    <= cfg_i.wdata[3:0];
          sgvf_pkg::REG_OUTPUT_DELAY:  output_delay_q  <= cfg_i.wdata[4:0];
          sgvf_pkg::REG_INVERSE_SCALE: inverse_scale_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      if (in_acc && in_i.command == sgvf_pkg::CMD_PUSH_SAMPLE) begin
        if (wp_q == sgvf_pkg::HIST_AW'(sgvf_pkg::HISTORY_DEPTH - 1)) begin
          wp_q <= '0;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
        if (fill_q != sgvf_pkg::FILL_W'(sgvf_pkg::HISTORY_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      sgvf_pkg::ST_START: begin
        rd_ptr_q <= sgvf_pkg::HIST_AW'(start_ptr_w);
        tap_q    <= '0;
        taps_q   <= taps_c;
        ax_q     <= sgvf_pkg::AX_X;
        win_q    <= win_ok;
        clip_q   <= 1'b0;
        for (int a = 0; a < 3; a++) begin
          acc_q[a] <= '0;
          res_q[a] <= '0;
        end
      end
      sgvf_pkg::ST_MUL: prod_q <= mul_p;
      sgvf_pkg::ST_ACC: begin
        acc_q[ax_q] <= acc_q[ax_q] + (prod_q >>> 8);
        if (ax_q == sgvf_pkg::AX_Z) begin
          ax_q  <= sgvf_pkg::AX_X;
          tap_q <= tap_q + 1'b1;
          if (rd_ptr_q == sgvf_pkg::HIST_AW'(sgvf_pkg::HISTORY_DEPTH - 1)) begin
            rd_ptr_q <= '0;
          end else begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
          end
        end else begin
          ax_q <= ax_q + 1'b1;
        end
      end
      sgvf_pkg::ST_RND: begin
        s_q    <= sat_rnd.val;
        clip_q <= clip_q | sat_rnd.clip;
      end
      sgvf_pkg::ST_SMUL: prod_q <= mul_p;
      sgvf_pkg::ST_SACC: begin
        res_q[ax_q] <= sat_scl.val;
        clip_q      <= clip_q | sat_scl.clip;
        ax_q        <= (ax_q == sgvf_pkg::AX_Z) ? sgvf_pkg::AX_X : ax_q + 1'b1;
      end
      default: ;
    endcase
    if (ctl.out_load) begin
      out_x_q    <= res_q[0];
      out_y_q    <= res_q[1];
      out_z_q    <= res_q[2];
      out_win_q  <= win_q;
      out_clip_q <= clip_q;
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign in_i.ready         = ctl.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = out_x_q;
  assign out_o.out_y        = out_y_q;
  assign out_o.out_z        = out_z_q;
  assign out_o.window_ready = out_win_q;
  assign out_o.clipped      = out_clip_q;

  `SGVF_ASSERT_NEXT(a_push_starts, in_acc && in_i.command == sgvf_pkg::CMD_PUSH_SAMPLE,
    state_q == sgvf_pkg::ST_START, "sample push did not start the sequencer")
  `SGVF_ASSERT(a_fill_bound, 1'b1, fill_q <= sgvf_pkg::FILL_W'(sgvf_pkg::HISTORY_DEPTH),
    "fill count beyond history depth")
  `SGVF_ASSERT(a_tap_bound, state_q == sgvf_pkg::ST_MUL, 5'(tap_q) < taps_q,
    "tap counter past window")
  `SGVF_ASSERT(a_not_ready_zero, out_valid_q && !out_win_q,
    out_x_q == 0 && out_y_q == 0 && out_z_q == 0 && !out_clip_q,
    "nonzero result without a full window")

endmodule
